[design/tgl_pkg.sv]
// Shared types and constants for the tile grid layout checker.
package tgl_pkg;

  // Configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Saturation point of the tile counter
  localparam logic [1:0] SEEN_MAX = 2'd2;

  // One incoming tile header
  typedef struct packed {
    logic [15:0] tile_x;
    logic [15:0] tile_y;
    logic [15:0] tile_width;
    logic [15:0] tile_height;
    logic        last_tile;
  } tgl_item_t;

  // One result
  typedef struct packed {
    logic layout_ok;
    logic verdict_final;
  } tgl_result_t;

  // Running grid state of the channel
  typedef struct packed {
    logic [15:0] ref_tile_width;
    logic [15:0] ref_tile_height;
    logic [16:0] cursor_x;
    logic [16:0] cursor_y;
    logic        row_ended;
    logic        layout_failed;
    logic [1:0]  tiles_seen;
  } tgl_state_t;

endpackage

[design/tile_grid_layout_checker.sv]
// Top level of the tile grid layout checker: registers, handshakes, checks.
//
// Usage: each transaction on the slave stream carries one sub-tile header of
// a frame channel, sorted row-major: s_tdata holds x, y, width and height,
// s_tlast marks the final tile of the channel. Each input transaction gives
// exactly one master transaction: m_tdata[0] is layout_ok (layout consistent
// so far, or the final verdict), m_tlast is set when it is the final verdict.
// After a final verdict the grid state clears for the next channel.
// frame_width / frame_height must be set through the write port (index 0 / 1)
// only while the block is idle, which the block does not enforce; both reset to 1.
// The result transaction passes through the input register, then the result
// register, which is loaded together with the grid state.
// Throughput: one tile per cycle while m_tready is high; the grid state update
// is combinational adds and compares from the input register.
// Reset (rst, synchronous) empties both registers and clears the grid state.
// When m_tready is low the result holds; the input register still takes one
// more tile, then s_tready drops until the result is taken.
module tile_grid_layout_checker import tgl_pkg::*; #(
  parameter int TARGET_TILE_SIZE = 512
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // tile_x, tile_y, tile_width, tile_height
  input  logic        s_tlast,   // last_tile
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // layout_ok, 7 zero bits
  output logic        m_tlast    // verdict_final
);

  logic        [15:0] frame_width;
  logic        [15:0] frame_height;
  logic               in_valid;
  tgl_item_t          in_item;
  logic               out_valid;
  tgl_result_t        out_result;
  tgl_state_t         st;
  tgl_state_t         st_next;
  tgl_result_t        result_next;
  logic               advance;
  logic               s_accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 16'd1;
      frame_height <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Handshake control
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_item.tile_x      <= s_tdata[15:0];
      in_item.tile_y      <= s_tdata[31:16];
      in_item.tile_width  <= s_tdata[47:32];
      in_item.tile_height <= s_tdata[63:48];
      in_item.last_tile   <= s_tlast;
    end
  end

  // Grid update and result
  tgl_place #(.TARGET_TILE_SIZE(TARGET_TILE_SIZE)) u_place (
    .item         (in_item),
    .st           (st),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .st_next      (st_next),
    .result       (result_next)
  );

  // Grid state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_result.layout_ok};
  assign m_tlast  = out_result.verdict_final;

  // A fresh channel never starts with a failure pending
  assert property (@(posedge clk) disable iff (rst)
    (st.tiles_seen == 2'd0) |-> !st.layout_failed)
    else $error("failure flag set with no tiles seen");

  // Tile counter saturates at two
  assert property (@(posedge clk) disable iff (rst)
    st.tiles_seen != 2'd3)
    else $error("tile counter overran");

  // A healthy grid always has a nonzero reference size
  assert property (@(posedge clk) disable iff (rst)
    (st.tiles_seen != 2'd0 && !st.layout_failed) |->
      (st.ref_tile_width != 16'd0 && st.ref_tile_height != 16'd0))
    else $error("zero reference size accepted");

  // A new result only appears after the input register held a tile
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid))
    else $error("result produced without a tile");

endmodule

[design/tgl_div_chk.sv]
// Checks that a tile dimension is a proper divisor of the target tile size.
module tgl_div_chk import tgl_pkg::*; #(
  parameter int TARGET_TILE_SIZE = 512
) (
  input  logic [15:0] size,
  output logic        ok
);

  // Each divisor of the target, fixed at elaboration, gets one compare
  logic [TARGET_TILE_SIZE-1:0] hit;

  assign hit[0] = 1'b0;

  for (genvar d = 1; d < TARGET_TILE_SIZE; d++) begin : g_div
    localparam bit IS_DIV = ((TARGET_TILE_SIZE % d) == 0);
    if (IS_DIV) begin : g_match
      assign hit[d] = (size == 16'(d));
    end else begin : g_skip
      assign hit[d] = 1'b0;
    end
  end

  // Flat OR over the compares, no ripple through the non-divisors
  assign ok = |hit;

endmodule

[design/tgl_place.sv]
// Next-state and result logic for one tile against the running grid state.
module tgl_place import tgl_pkg::*; #(
  parameter int TARGET_TILE_SIZE = 512
) (
  input  tgl_item_t   item,
  input  tgl_state_t  st,
  input  logic [15:0] frame_width,
  input  logic [15:0] frame_height,
  output tgl_state_t  st_next,
  output tgl_result_t result
);

  logic        first;
  logic        w_div_ok;
  logic        h_div_ok;
  logic [15:0] rw;
  logic [15:0] rh;
  logic [16:0] cx0;
  logic [16:0] cy0;
  logic        eol0;
  logic        fail0;
  logic        new_row;
  logic [17:0] row_below;
  logic [16:0] cx1;
  logic [16:0] cy1;
  logic        eol1;
  logic [17:0] bottom;
  logic [17:0] next_ref_x;
  logic [16:0] right_edge;
  logic        bad_row;
  logic        bad_h;
  logic        bad_x;
  logic        odd_w;
  logic        bad_w;
  logic        fail1;
  logic [1:0]  seen1;

  tgl_div_chk #(.TARGET_TILE_SIZE(TARGET_TILE_SIZE)) u_div_w (
    .size (item.tile_width),
    .ok   (w_div_ok)
  );

  tgl_div_chk #(.TARGET_TILE_SIZE(TARGET_TILE_SIZE)) u_div_h (
    .size (item.tile_height),
    .ok   (h_div_ok)
  );

  // First tile of a channel restarts the grid and sets the reference size
  assign first = (st.tiles_seen == 2'd0);
  assign rw    = first ? item.tile_width  : st.ref_tile_width;
  assign rh    = first ? item.tile_height : st.ref_tile_height;
  assign cx0   = first ? 17'd0 : st.cursor_x;
  assign cy0   = first ? 17'd0 : st.cursor_y;
  assign eol0  = first ? 1'b0  : st.row_ended;
  assign fail0 = first ? !(w_div_ok && h_div_ok) : st.layout_failed;

  // Row change: only after the row closed, directly below it
  assign new_row   = ({1'b0, item.tile_y} != cy0);
  assign row_below = {1'b0, cy0} + {2'b00, rh};
  assign bad_row   = new_row && (!eol0 || ({2'b00, item.tile_y} != row_below));
  assign cy1       = new_row ? {1'b0, item.tile_y} : cy0;
  assign cx1       = new_row ? 17'd0 : cx0;
  assign eol1      = new_row ? 1'b0  : eol0;

  // Height may differ only in the bottom row
  assign bottom = {1'b0, cy1} + {2'b00, item.tile_height};
  assign bad_h  = (item.tile_height != rh) && (bottom != {2'b00, frame_height});

  // Tile must continue the row
  assign bad_x = ({1'b0, item.tile_x} != cx1);

  // Width may differ only on the tile that closes the row
  assign next_ref_x = {1'b0, cx1} + {2'b00, rw};
  assign right_edge = {1'b0, item.tile_x} + {1'b0, item.tile_width};
  assign odd_w      = (item.tile_width != rw) || (next_ref_x >= {2'b00, frame_width});
  assign bad_w      = odd_w && (right_edge != {1'b0, frame_width});

  assign fail1 = fail0 || bad_row || bad_h || bad_x || bad_w;
  assign seen1 = (st.tiles_seen < SEEN_MAX) ? st.tiles_seen + 2'd1 : st.tiles_seen;

  // State update; cursors move only on a placed tile
  always_comb begin
    st_next                 = st;
    st_next.ref_tile_width  = rw;
    st_next.ref_tile_height = rh;
    st_next.cursor_x        = cx0;
    st_next.cursor_y        = cy0;
    st_next.row_ended       = eol0;
    st_next.layout_failed   = fail1;
    st_next.tiles_seen      = seen1;
    if (!fail1) begin
      st_next.cursor_x  = cx1 + {1'b0, item.tile_width};
      st_next.cursor_y  = cy1;
      st_next.row_ended = eol1 | odd_w;
    end
    if (item.last_tile) begin
      st_next = '0;
    end
  end

  // Result
  always_comb begin
    result.verdict_final = item.last_tile;
    if (item.last_tile) begin
      result.layout_ok = !fail1 && (seen1 >= SEEN_MAX);
    end else begin
      result.layout_ok = !fail1;
    end
  end

endmodule
